@@ hw/rtl/cms_pkg.sv @@
package cms_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int MAX_ROWS  = 4;
  localparam int TABLE_SIZE = MAX_WIDTH * MAX_ROWS;
  localparam int IDX_W  = $clog2(TABLE_SIZE);
  localparam int USED_W = $clog2(TABLE_SIZE + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int ROWS_W = $clog2(MAX_ROWS + 1);
  localparam int QDEPTH = 4;

  localparam logic [63:0] MIX_ADD  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1 = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2 = 64'h94D049BB133111EB;

  localparam logic [1:0] FN_RECORD   = 2'd0;
  localparam logic [1:0] FN_ESTIMATE = 2'd1;
  localparam logic [1:0] FN_AGE      = 2'd2;
  localparam logic [1:0] FN_CLEAR    = 2'd3;

  localparam logic [1:0] REG_ROW_WIDTH = 2'd0;
  localparam logic [1:0] REG_ROW_COUNT = 2'd1;
  localparam logic [1:0] REG_SEED      = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  typedef struct packed {
    logic [COL_W-1:0]  width;
    logic [ROWS_W-1:0] rows;
    logic [31:0]       seed;
    logic [31:0]       threshold;
  } cms_cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cms_entry_t;

endpackage

@@ hw/rtl/cms_if.sv @@
interface cms_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [31:0] hash;
  modport source (output valid, func, hash, input ready);
  modport sink (input valid, func, hash, output ready);
endinterface

interface cms_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] estimate;
  logic       aged;
  modport source (output valid, estimate, aged, input ready);
  modport sink (input valid, estimate, aged, output ready);
endinterface

@@ hw/rtl/count_min_sketch_aging_core.sv @@
// Count-min sketch of 4 x 1024 8-bit counters with threshold aging. After reset the
// table is cleared, during which no word is accepted. A record or estimate word
// runs once per active row through the hash front end (splitmix mix on one
// shared 32x32 multiplier, then a column remainder), plus an accept step,
// overlapped with the per-row lookup in the table unit; one word is in the
// front end at a time.
// Age walks clamped width * rows counters at one per cycle, clear walks all 4096.
// Config writes are to be made only while the block is idle.
module count_min_sketch_aging_core
  import cms_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  cms_req_if.sink     req,
  cms_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [10:0] row_width;
  logic [2:0]  row_count;
  logic [31:0] base_seed;
  logic [31:0] aging_threshold;

  cms_cfg_t   cfg;
  logic       init_done;
  logic       f_valid;
  logic       f_ready;
  cms_entry_t f_entry;
  logic       b_valid;
  logic       b_ready;
  cms_entry_t b_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width       <= 11'd1024;
      row_count       <= 3'd4;
      base_seed       <= '0;
      aging_threshold <= 32'd10240;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ROW_WIDTH: row_width       <= cfg_data[10:0];
        REG_ROW_COUNT: row_count       <= cfg_data[2:0];
        REG_SEED:      base_seed       <= cfg_data;
        REG_THRESHOLD: aging_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_width == '0) begin
      cfg.width = COL_W'(1);
    end else if (row_width > COL_W'(MAX_WIDTH)) begin
      cfg.width = COL_W'(MAX_WIDTH);
    end else begin
      cfg.width = row_width;
    end
    if (row_count == '0) begin
      cfg.rows = ROWS_W'(1);
    end else if (row_count > ROWS_W'(MAX_ROWS)) begin
      cfg.rows = ROWS_W'(MAX_ROWS);
    end else begin
      cfg.rows = row_count;
    end
    cfg.seed      = base_seed;
    cfg.threshold = aging_threshold;
  end

  cms_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg       (cfg),
    .init_done (init_done),
    .q_valid   (f_valid),
    .q_ready   (f_ready),
    .q_entry   (f_entry)
  );

  cms_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_entry (f_entry),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_entry  (b_entry)
  );

  cms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (b_valid),
    .q_ready   (b_ready),
    .q_entry   (b_entry),
    .init_done (init_done),
    .rsp       (rsp)
  );

endmodule

@@ hw/rtl/cms_front.sv @@
module cms_front
  import cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cms_req_if.sink    req,
  input  cms_cfg_t   cfg,
  input  logic       init_done,
  output logic       q_valid,
  input  logic       q_ready,
  output cms_entry_t q_entry
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_ADD  = 3'd1;
  localparam logic [2:0] F_M1   = 3'd2;
  localparam logic [2:0] F_X2   = 3'd3;
  localparam logic [2:0] F_M2   = 3'd4;
  localparam logic [2:0] F_FOLD = 3'd5;
  localparam logic [2:0] F_MOD  = 3'd6;
  localparam logic [2:0] F_PUSH = 3'd7;

  logic [2:0]       state;
  logic [1:0]       func;
  logic [31:0]      hash;
  logic [ROW_W-1:0] row;
  logic [IDX_W-1:0] base;
  logic [31:0]      seed;
  logic [63:0]      a;
  logic [63:0]      acc;
  logic [2:0]       cnt;
  logic [31:0]      h;
  logic [COL_W-1:0] rem;

  logic [63:0]      k;
  logic [31:0]      op_a;
  logic [31:0]      op_b;
  logic [63:0]      prod;
  logic [63:0]      x_add;
  logic [63:0]      x_fold;
  logic [COL_W-1:0] rem_next;
  logic             last_row;
  logic             hashed;

  assign req.ready = (state == F_IDLE) && init_done;
  assign hashed    = (func == FN_RECORD) || (func == FN_ESTIMATE);
  assign last_row  = !hashed || (ROWS_W'({1'b0, row}) + ROWS_W'(1) == cfg.rows);

  // 64x64 product mod 2^64 from three 32x32 partials
  assign k    = (state == F_M1) ? MIX_MUL1 : MIX_MUL2;
  assign op_a = (cnt == 3'd2) ? a[63:32] : a[31:0];
  assign op_b = (cnt == 3'd1) ? k[63:32] : k[31:0];
  assign prod = 64'(op_a) * 64'(op_b);

  assign x_add  = {hash, seed} + MIX_ADD;
  assign x_fold = acc ^ (acc >> 31);

  // four restoring remainder steps per cycle
  always_comb begin
    logic [COL_W:0] t;
    rem_next = rem;
    for (int i = 0; i < 4; i++) begin
      t = {rem_next, h[31-i]};
      if (t >= {1'b0, cfg.width}) begin
        t = t - {1'b0, cfg.width};
      end
      rem_next = t[COL_W-1:0];
    end
  end

  assign q_valid      = (state == F_PUSH);
  assign q_entry.op   = func;
  assign q_entry.idx  = hashed ? base + IDX_W'(rem) : '0;
  assign q_entry.last = last_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      cnt   <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (req.valid && req.ready) begin
            func <= req.func;
            hash <= req.hash;
            row  <= '0;
            base <= '0;
            seed <= cfg.seed;
            if (req.func == FN_AGE || req.func == FN_CLEAR) begin
              state <= F_PUSH;
            end else begin
              state <= F_ADD;
            end
          end
        end
        F_ADD: begin
          a     <= x_add ^ (x_add >> 30);
          cnt   <= '0;
          state <= F_M1;
        end
        F_M1, F_M2: begin
          if (cnt == 3'd0) begin
            acc <= prod;
          end else begin
            acc[63:32] <= acc[63:32] + prod[31:0];
          end
          cnt <= cnt + 3'd1;
          if (cnt == 3'd2) begin
            state <= (state == F_M1) ? F_X2 : F_FOLD;
          end
        end
        F_X2: begin
          a     <= acc ^ (acc >> 27);
          cnt   <= '0;
          state <= F_M2;
        end
        F_FOLD: begin
          h     <= x_fold[63:32] ^ x_fold[31:0];
          rem   <= '0;
          cnt   <= '0;
          state <= F_MOD;
        end
        F_MOD: begin
          rem <= rem_next;
          h   <= h << 4;
          cnt <= cnt + 3'd1;
          if (cnt == 3'd7) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            if (last_row) begin
              state <= F_IDLE;
            end else begin
              row   <= row + ROW_W'(1);
              base  <= base + IDX_W'(cfg.width);
              seed  <= seed + 32'd1;
              state <= F_ADD;
            end
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cms_queue.sv @@
module cms_queue
  import cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  cms_entry_t push_entry,
  output logic       pop_valid,
  input  logic       pop_ready,
  output cms_entry_t pop_entry
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  cms_entry_t       slots [QDEPTH];
  logic [PTR_W-1:0] wp;
  logic [PTR_W-1:0] rp;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != CNT_W'(QDEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_entry  = slots[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= '0;
      rp   <= '0;
      fill <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PTR_W'(QDEPTH - 1)) ? '0 : wp + PTR_W'(1);
      end
      if (do_pop) begin
        rp <= (rp == PTR_W'(QDEPTH - 1)) ? '0 : rp + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ hw/rtl/cms_back.sv @@
module cms_back
  import cms_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cms_cfg_t   cfg,
  input  logic       q_valid,
  output logic       q_ready,
  input  cms_entry_t q_entry,
  output logic       init_done,
  cms_rsp_if.source  rsp
);

  localparam logic [1:0] B_CLR  = 2'd0;
  localparam logic [1:0] B_IDLE = 2'd1;
  localparam logic [1:0] B_RD   = 2'd2;
  localparam logic [1:0] B_AGE  = 2'd3;

  logic [7:0] mem [TABLE_SIZE];

  logic [1:0]        state;
  cms_entry_t        e;
  logic [31:0]       count;
  logic [7:0]        min_val;
  logic [USED_W-1:0] rptr;
  logic              wv;
  logic [IDX_W-1:0]  wa;
  logic [IDX_W-1:0]  cptr;
  logic              clr_res;
  logic              out_valid;
  logic [7:0]        est_r;
  logic              aged_r;
  logic [7:0]        rdata;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [7:0]        wdata;
  logic [IDX_W-1:0]  raddr;
  logic [USED_W-1:0] used;
  logic [31:0]       count_inc;
  logic [7:0]        min_next;

  assign used      = USED_W'(cfg.width * cfg.rows);
  assign count_inc = count + 32'd1;
  assign min_next  = (rdata < min_val) ? rdata : min_val;
  assign init_done = (state != B_CLR) || clr_res;
  assign q_ready   = (state == B_IDLE) && !out_valid;

  assign rsp.valid    = out_valid;
  assign rsp.estimate = est_r;
  assign rsp.aged     = aged_r;

  always_comb begin
    we    = 1'b0;
    waddr = e.idx;
    wdata = '0;
    raddr = q_entry.idx;
    unique case (state)
      B_CLR: begin
        we    = 1'b1;
        waddr = cptr;
      end
      B_RD: begin
        we    = (e.op == FN_RECORD);
        wdata = (rdata == 8'hFF) ? rdata : rdata + 8'd1;
      end
      B_AGE: begin
        we    = wv;
        waddr = wa;
        wdata = rdata >> 1;
        raddr = rptr[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_CLR;
      cptr      <= '0;
      clr_res   <= 1'b0;
      count     <= '0;
      min_val   <= 8'hFF;
      wv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        B_CLR: begin
          cptr <= cptr + IDX_W'(1);
          if (cptr == IDX_W'(TABLE_SIZE - 1)) begin
            state <= B_IDLE;
            if (clr_res) begin
              out_valid <= 1'b1;
              est_r     <= '0;
              aged_r    <= 1'b0;
              clr_res   <= 1'b0;
            end
          end
        end
        B_IDLE: begin
          if (q_valid && q_ready) begin
            e <= q_entry;
            unique case (q_entry.op)
              FN_RECORD, FN_ESTIMATE: state <= B_RD;
              FN_AGE: begin
                rptr  <= '0;
                wv    <= 1'b0;
                state <= B_AGE;
              end
              FN_CLEAR: begin
                cptr    <= '0;
                clr_res <= 1'b1;
                count   <= '0;
                state   <= B_CLR;
              end
              default: state <= B_IDLE;
            endcase
          end
        end
        B_RD: begin
          state <= B_IDLE;
          if (e.op == FN_RECORD) begin
            if (e.last) begin
              if (count_inc >= cfg.threshold) begin
                rptr  <= '0;
                wv    <= 1'b0;
                state <= B_AGE;
              end else begin
                count     <= count_inc;
                out_valid <= 1'b1;
                est_r     <= '0;
                aged_r    <= 1'b0;
              end
            end
          end else if (e.last) begin
            out_valid <= 1'b1;
            est_r     <= min_next;
            aged_r    <= 1'b0;
            min_val   <= 8'hFF;
          end else begin
            min_val <= min_next;
          end
        end
        B_AGE: begin
          // read one entry ahead, write back the halved value in the next cycle
          if (rptr < used) begin
            rptr <= rptr + USED_W'(1);
            wv   <= 1'b1;
            wa   <= rptr[IDX_W-1:0];
          end else begin
            wv <= 1'b0;
            if (!wv) begin
              count     <= '0;
              out_valid <= 1'b1;
              est_r     <= '0;
              aged_r    <= 1'b1;
              state     <= B_IDLE;
            end
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/cms_check.sv @@
module cms_check (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_estimate,
  input logic       out_aged
);

  // table clear after reset blocks input
  a_reset_blocks: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready right after reset");

  // an aging word never carries an estimate
  a_aged_no_est: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_aged |-> out_estimate == 8'd0)
    else $error("aged word with nonzero estimate");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output word dropped");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_estimate) && $stable(out_aged))
    else $error("output word changed while stalled");

endmodule

bind count_min_sketch_aging_core cms_check u_cms_check (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (req.ready),
  .out_valid    (rsp.valid),
  .out_ready    (rsp.ready),
  .out_estimate (rsp.estimate),
  .out_aged     (rsp.aged)
);

@@ sim/tb_ifs.sv @@
`timescale 1ns / 1ps
// Interfaces are shared with the RTL (cms_if.sv); this file only holds the
// scoreboard word type used by the testbench.
package tb_types_pkg;
  typedef struct packed {
    logic [7:0] estimate;
    logic       aged;
  } sketch_word_t;
endpackage

@@ sim/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import cms_pkg::*;
  import tb_types_pkg::*;

  localparam int LIMIT = 20000000;

  // Shadow copy of the sketch: table, access count and registers.
  class sketch_board;
    logic [7:0]   counters [TABLE_SIZE];
    logic [31:0]  accesses;
    logic [10:0]  width_reg;
    logic [2:0]   rows_reg;
    logic [31:0]  seed_reg;
    logic [31:0]  thresh_reg;
    sketch_word_t pending [$];
    int           errors;

    function void reset_state();
      foreach (counters[i]) counters[i] = 8'd0;
      accesses = 32'd0;
      width_reg = 11'd1024;
      rows_reg = 3'd4;
      seed_reg = 32'd0;
      thresh_reg = 32'd10240;
      pending.delete();
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] index, logic [31:0] data);
      case (index)
        REG_ROW_WIDTH: width_reg = data[10:0];
        REG_ROW_COUNT: rows_reg = data[2:0];
        REG_SEED:      seed_reg = data;
        REG_THRESHOLD: thresh_reg = data;
      endcase
    endfunction

    function int unsigned eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_rows();
      if (rows_reg == 0) return 1;
      if (rows_reg > MAX_ROWS) return MAX_ROWS;
      return rows_reg;
    endfunction

    function int unsigned slot(logic [31:0] hash, int unsigned r, int unsigned w);
      logic [63:0] x;
      logic [31:0] sd;
      logic [31:0] folded;
      sd = seed_reg + r;
      x = {hash, sd} + MIX_ADD;
      x = (x ^ (x >> 30)) * MIX_MUL1;
      x = (x ^ (x >> 27)) * MIX_MUL2;
      x = x ^ (x >> 31);
      folded = x[63:32] ^ x[31:0];
      return r * w + (folded % w);
    endfunction

    function void halve();
      int unsigned used;
      used = eff_width() * eff_rows();
      for (int unsigned i = 0; i < used; i++) counters[i] = counters[i] >> 1;
      accesses = 32'd0;
    endfunction

    function void note_word(logic [1:0] func, logic [31:0] hash);
      int unsigned w, rows, idx;
      sketch_word_t res;
      w = eff_width();
      rows = eff_rows();
      res = '0;
      case (func)
        FN_RECORD: begin
          for (int unsigned r = 0; r < rows; r++) begin
            idx = slot(hash, r, w);
            if (counters[idx] != 8'hff) counters[idx]++;
          end
          accesses = accesses + 1;
          if (accesses >= thresh_reg) begin
            halve();
            res.aged = 1'b1;
          end
        end
        FN_ESTIMATE: begin
          res.estimate = 8'hff;
          for (int unsigned r = 0; r < rows; r++) begin
            idx = slot(hash, r, w);
            if (counters[idx] < res.estimate) res.estimate = counters[idx];
          end
        end
        FN_AGE: begin
          halve();
          res.aged = 1'b1;
        end
        default: begin
          foreach (counters[i]) counters[i] = 8'd0;
          accesses = 32'd0;
        end
      endcase
      pending.push_back(res);
    endfunction

    function void check_word(logic [7:0] estimate, logic aged);
      sketch_word_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word est=%0d aged=%0d", $time, estimate, aged);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (estimate !== exp.estimate) begin
        $display("%0t: estimate expected %0d actual %0d", $time, exp.estimate, estimate);
        errors++;
      end
      if (aged !== exp.aged) begin
        $display("%0t: aged expected %0d actual %0d", $time, exp.aged, aged);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ROW_WIDTH;
  logic [31:0] cfg_data = '0;

  cms_req_if req ();
  cms_rsp_if rsp ();

  count_min_sketch_aging_core uut (
    .clk(clk), .rst(rst), .req(req.sink), .rsp(rsp.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sketch_board board = new();
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;
  int cycles = 0;
  logic hot_mode = 1'b0;
  logic [31:0] hot_hashes [8];

  initial begin
    req.valid = 1'b0;
    req.func = FN_RECORD;
    req.hash = '0;
    rsp.ready = 1'b0;
  end

  // Receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) board.check_word(rsp.estimate, rsp.aged);
    if (!rst && req.valid && req.ready) board.note_word(req.func, req.hash);
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // valid stays up after a word is taken; the next idle cycle, drain or
  // register write lowers it
  task automatic send_word(logic [1:0] func, logic [31:0] hash);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.func <= func;
    req.hash <= hash;
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    // an age or clear walk may still be running after the last word
    repeat (4200) @(negedge clk);
  endtask

  task automatic set_reg(logic [1:0] index, logic [31:0] data);
    req.valid <= 1'b0;
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.write_reg(index, data);
    @(negedge clk);
  endtask

  task automatic set_all(logic [31:0] w, logic [31:0] r, logic [31:0] s, logic [31:0] t);
    drain();
    set_reg(REG_ROW_WIDTH, w);
    set_reg(REG_ROW_COUNT, r);
    set_reg(REG_SEED, s);
    set_reg(REG_THRESHOLD, t);
  endtask

  task automatic random_words(int n);
    logic [1:0] f;
    logic [31:0] h;
    int p;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 55) f = FN_RECORD;
      else if (p < 93) f = FN_ESTIMATE;
      else if (p < 98) f = FN_AGE;
      else f = FN_CLEAR;
      // mostly a small hot set so counters climb and estimates are nonzero
      h = ($urandom_range(9) < 8) ? hot_hashes[$urandom_range(7)] : $urandom;
      send_word(f, h);
    end
  endtask

  initial begin
    board.reset_state();
    foreach (hot_hashes[i]) hot_hashes[i] = $urandom;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // directed: field extremes, every function, saturation, zero threshold
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_word(FN_ESTIMATE, 32'h0);
    send_word(FN_RECORD, 32'h0);
    send_word(FN_RECORD, 32'hffff_ffff);
    send_word(FN_ESTIMATE, 32'hffff_ffff);
    send_word(FN_AGE, 32'h0);
    send_word(FN_RECORD, 32'h1234_5678);
    send_word(FN_CLEAR, 32'hffff_ffff);
    send_word(FN_ESTIMATE, 32'h1234_5678);
    // width 0 acts as 1, rows 0 acts as 1: one counter that every record hits
    set_all(0, 0, 32'hffff_ffff, 32'hffff_ffff);
    for (int i = 0; i < 8; i++) send_word(FN_RECORD, $urandom);
    send_word(FN_ESTIMATE, 32'h5555_5555);
    // width above max, rows above max, zero threshold
    set_all(11'h7ff, 7, 32'hffff_fffe, 0);
    send_word(FN_RECORD, 32'haaaa_aaaa);
    send_word(FN_ESTIMATE, 32'haaaa_aaaa);
    // threshold lowered below the count
    set_all(1024, 4, 0, 100);
    for (int i = 0; i < 3; i++) send_word(FN_RECORD, 32'h0);
    drain();
    set_reg(REG_THRESHOLD, 2);
    send_word(FN_RECORD, 32'h0);

    // saturation: narrow table, many records, high threshold
    set_all(1, 1, 7, 32'hffff_ffff);
    for (int i = 0; i < 260; i++) send_word(FN_RECORD, $urandom);
    send_word(FN_ESTIMATE, $urandom);

    set_all(16, 2, $urandom, 40);
    send_idle_pct = 20;
    recv_idle_pct = 62;
    random_words(450);

    // receiver holds off while the sender keeps offering
    hold_off = 400;
    random_words(30);
    drain();

    set_all($urandom_range(1, 1024), $urandom_range(1, 4), $urandom, 1);
    send_idle_pct = 62;
    recv_idle_pct = 20;
    random_words(450);

    set_all(64, 3, 32'hffff_ffff, 25);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_words(450);
    set_all(1024, 4, 0, 10240);
    random_words(60);

    drain();
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
hw/rtl/cms_pkg.sv
hw/rtl/cms_if.sv
hw/rtl/cms_front.sv
hw/rtl/cms_queue.sv
hw/rtl/cms_back.sv
hw/rtl/count_min_sketch_aging_core.sv
hw/rtl/cms_check.sv
sim/tb_ifs.sv
sim/tb.sv
